@@ rtl/vertex_transform_perspective_top_defines.svh @@
// ---------------------------------------------------------------------------
// vertex transform assertion macros
// concurrent assertion helpers, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VTP_ASSERT(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (expr)) else $error("vtp assertion failed");
`define VTP_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("vtp assertion failed");
`else
`define VTP_ASSERT(lbl, expr)
`define VTP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/vtp_pkg.sv @@
// ---------------------------------------------------------------------------
// vtp_pkg
// shared constants and types of the vertex transform
// ---------------------------------------------------------------------------
package vtp_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NCOEF         = 12;
  localparam int WORD_W        = 32;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_POINT = 1'b1
  } kind_t;

  typedef logic signed [WORD_W-1:0] word_t;
endpackage

@@ rtl/vertex_transform_perspective_top.sv @@
// ---------------------------------------------------------------------------
// vertex_transform_perspective_top
// affine 4x3 vertex transform with optional perspective divide, q16.16
// ---------------------------------------------------------------------------
// in channel: one transaction per item; in_tuser is the kind. a load
//   transaction writes one of twelve coefficients at acceptance (slots 12..15
//   are ignored) and gives no result; a point transaction gives one result.
// out channel: out_tdata holds x, y, z; out_tuser holds was_divided and
//   saturated.
// cfg port: cfg_wr_en writes cfg_wr_data into the perspective enable.
// throughput: one transaction per cycle unless stalled, points and loads
//   mixed freely.
// pipeline: input, multiply, sum and saturate stages, restoring divider
//   (one quotient bit per stage, 32 + FRAC_BITS stages), output register.
// reset: matrix returns to identity, perspective off, pipeline emptied.
// stall: when out_tready is low with a result waiting the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "vertex_transform_perspective_top_defines.svh"

module vertex_transform_perspective_top
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_index, coef_value, point_x, point_y, point_z, zero pad
  input  logic [135:0] in_tdata,
  // kind
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata,
  // was_divided, saturated
  output logic [1:0]   out_tuser
);
  localparam int QW = WORD_W + FRAC_BITS;
  localparam int SW = 2 * WORD_W + 2;
  localparam word_t ONE_FX = word_t'(32'sd1 <<< FRAC_BITS);
  localparam logic signed [SW-1:0] SMAX = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-31){1'b1}}, {31{1'b0}}};
  localparam logic [QW-1:0] QMAX = QW'(32'h7fffffff);
  localparam logic [QW-1:0] QMIN = QW'(32'h80000000);

  logic        en;
  logic [3:0]  in_idx;
  word_t       in_cval;
  word_t       in_pt [3];
  kind_t       in_kind;
  logic        ld0_c;

  word_t       coef_r [NCOEF];
  logic        pe_r;

  logic        s1_v_r, s1_pe_r;
  word_t       s1_p_r [3];
  word_t       s1_m_r [NCOEF];

  logic        s2_v_r, s2_pe_r;
  logic signed [63:0] prod_r [9];
  word_t       s2_t_r [3];

  logic        s3_v_r, s3_pe_r;
  logic signed [SW-1:0] sum_r [3];
  word_t       s3_t_r [3];

  logic signed [SW-1:0] sh_c [3];
  logic signed [SW-1:0] ew_c [3];
  word_t       e_c [3];
  logic [2:0]  esat_c;

  logic          v_r   [QW+1];
  logic [QW-1:0] dx_r  [QW+1];
  logic [QW-1:0] dy_r  [QW+1];
  logic [31:0]   rx_r  [QW+1];
  logic [31:0]   ry_r  [QW+1];
  logic [31:0]   den_r [QW+1];
  word_t         ex_r  [QW+1];
  word_t         ey_r  [QW+1];
  word_t         ez_r  [QW+1];
  logic          nx_r  [QW+1];
  logic          ny_r  [QW+1];
  logic          dv_r  [QW+1];
  logic          sat_r [QW+1];

  logic [32:0]   tx_c [QW];
  logic [32:0]   ty_c [QW];
  logic          gx_c [QW];
  logic          gy_c [QW];

  word_t       fx_c, fy_c;
  logic        fsat_c;

  logic        out_v_r;
  word_t       ox_r, oy_r, oz_r;
  logic        odv_r, osat_r;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign in_idx    = in_tdata[3:0];
  assign in_cval   = in_tdata[35:4];
  assign in_pt[0]  = in_tdata[67:36];
  assign in_pt[1]  = in_tdata[99:68];
  assign in_pt[2]  = in_tdata[131:100];
  assign in_kind   = kind_t'(in_tuser);
  assign ld0_c     = in_tvalid && in_tready && in_kind == KIND_LOAD && in_idx == 4'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_FX : '0;
      end
    end else if (in_tvalid && in_tready && in_kind == KIND_LOAD &&
                 in_idx < 4'(NCOEF)) begin
      coef_r[in_idx] <= in_cval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe_r <= 1'b0;
    end else if (cfg_wr_en) begin
      pe_r <= cfg_wr_data;
    end
  end

  // input, multiply and sum stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid && in_kind == KIND_POINT;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pe_r <= pe_r;
      s1_p_r  <= in_pt;
      s1_m_r  <= coef_r;
      s2_pe_r <= s1_pe_r;
      s3_pe_r <= s2_pe_r;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r*3+c] <= s1_p_r[r] * s1_m_r[r*3+c];
        end
      end
      for (int c = 0; c < 3; c++) begin
        s2_t_r[c] <= s1_m_r[9+c];
        s3_t_r[c] <= s2_t_r[c];
        sum_r[c]  <= SW'(prod_r[c]) + SW'(prod_r[3+c]) + SW'(prod_r[6+c]);
      end
    end
  end

  // floor, translate and saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh_c[c] = sum_r[c] >>> FRAC_BITS;
      ew_c[c] = sh_c[c] + SW'(s3_t_r[c]);
      if (ew_c[c] > SMAX) begin
        e_c[c] = word_t'(SMAX[31:0]);
        esat_c[c] = 1'b1;
      end else if (ew_c[c] < SMIN) begin
        e_c[c] = word_t'(SMIN[31:0]);
        esat_c[c] = 1'b1;
      end else begin
        e_c[c] = word_t'(ew_c[c][31:0]);
        esat_c[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0]  <= QW'(e_c[0][31] ? 32'(-e_c[0]) : 32'(e_c[0])) << FRAC_BITS;
      dy_r[0]  <= QW'(e_c[1][31] ? 32'(-e_c[1]) : 32'(e_c[1])) << FRAC_BITS;
      rx_r[0]  <= '0;
      ry_r[0]  <= '0;
      den_r[0] <= e_c[2][31] ? 32'(-e_c[2]) : 32'(e_c[2]);
      ex_r[0]  <= e_c[0];
      ey_r[0]  <= e_c[1];
      ez_r[0]  <= e_c[2];
      nx_r[0]  <= e_c[0][31] ^ e_c[2][31];
      ny_r[0]  <= e_c[1][31] ^ e_c[2][31];
      dv_r[0]  <= s3_pe_r && e_c[2] != '0;
      sat_r[0] <= |esat_c;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    always_comb begin
      tx_c[k] = {rx_r[k], dx_r[k][QW-1]};
      ty_c[k] = {ry_r[k], dy_r[k][QW-1]};
      gx_c[k] = tx_c[k] >= {1'b0, den_r[k]};
      gy_c[k] = ty_c[k] >= {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1]  <= gx_c[k] ? 32'(tx_c[k] - {1'b0, den_r[k]}) : tx_c[k][31:0];
        ry_r[k+1]  <= gy_c[k] ? 32'(ty_c[k] - {1'b0, den_r[k]}) : ty_c[k][31:0];
        dx_r[k+1]  <= {dx_r[k][QW-2:0], gx_c[k]};
        dy_r[k+1]  <= {dy_r[k][QW-2:0], gy_c[k]};
        den_r[k+1] <= den_r[k];
        ex_r[k+1]  <= ex_r[k];
        ey_r[k+1]  <= ey_r[k];
        ez_r[k+1]  <= ez_r[k];
        nx_r[k+1]  <= nx_r[k];
        ny_r[k+1]  <= ny_r[k];
        dv_r[k+1]  <= dv_r[k];
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  // quotient sign and clamp
  always_comb begin
    fsat_c = sat_r[QW];
    fx_c   = ex_r[QW];
    fy_c   = ey_r[QW];
    if (dv_r[QW]) begin
      if (!nx_r[QW] && dx_r[QW] > QMAX) begin
        fx_c = word_t'(32'h7fffffff);
        fsat_c = 1'b1;
      end else if (nx_r[QW] && dx_r[QW] > QMIN) begin
        fx_c = word_t'(32'h80000000);
        fsat_c = 1'b1;
      end else begin
        fx_c = nx_r[QW] ? word_t'(-dx_r[QW][31:0]) : word_t'(dx_r[QW][31:0]);
      end
      if (!ny_r[QW] && dy_r[QW] > QMAX) begin
        fy_c = word_t'(32'h7fffffff);
        fsat_c = 1'b1;
      end else if (ny_r[QW] && dy_r[QW] > QMIN) begin
        fy_c = word_t'(32'h80000000);
        fsat_c = 1'b1;
      end else begin
        fy_c = ny_r[QW] ? word_t'(-dy_r[QW][31:0]) : word_t'(dy_r[QW][31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r   <= fx_c;
      oy_r   <= fy_c;
      oz_r   <= ez_r[QW];
      odv_r  <= dv_r[QW];
      osat_r <= fsat_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {oz_r, oy_r, ox_r};
  assign out_tuser  = {osat_r, odv_r};

  `VTP_ASSERT(a_div_nonzero_z, !out_tvalid || !out_tuser[0] || out_tdata[95:64] != 32'd0)
  `VTP_ASSERT(a_stall_only_full, in_tready || out_tvalid)
  `VTP_ASSERT_NEXT(a_coef_load, ld0_c, coef_r[0] == $past(in_cval))
endmodule

@@ bench/vertex_transform_perspective_top_test.sv @@
// ---------------------------------------------------------------------------
// vertex_transform_perspective_top_test
// drives coefficient loads and points through the vertex transform with
// random idling on both channels, predicts each transformed point with an
// internal fixed-point model and checks every output transaction in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_transform_perspective_top_test;
  import vtp_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = FB + 37;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    kind_t kind;
    logic [3:0] slot;
    word_t coef;
    word_t px;
    word_t py;
    word_t pz;
  } vtx_item_t;

  typedef struct {
    word_t rx;
    word_t ry;
    word_t rz;
    logic divided;
    logic clamped;
  } vtx_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [135:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;

  vtx_item_t pending_items[$];
  vtx_result_t expected_points[$];
  word_t coefs[NCOEF];
  logic persp_on;
  int errors;
  int idle_cycles;
  int send_wait;
  int recv_wait;

  vertex_transform_perspective_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v, ref logic flag);
    if (v > S32_MAX) begin
      flag = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      flag = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic longint column_dot(word_t x, word_t y, word_t z, int c,
                                        ref logic flag);
    logic signed [127:0] acc;
    acc = 128'(signed'(x)) * coefs[c] + 128'(signed'(y)) * coefs[3 + c]
        + 128'(signed'(z)) * coefs[6 + c];
    acc = (acc >>> FB) + 128'(signed'(coefs[9 + c]));
    if (acc > S32_MAX) begin
      flag = 1'b1;
      return S32_MAX;
    end
    if (acc < S32_MIN) begin
      flag = 1'b1;
      return S32_MIN;
    end
    return longint'(acc);
  endfunction

  function automatic vtx_result_t transform_point(vtx_item_t it);
    vtx_result_t r;
    longint ex;
    longint ey;
    longint ez;
    logic flag;
    flag = 1'b0;
    ex = column_dot(it.px, it.py, it.pz, 0, flag);
    ey = column_dot(it.px, it.py, it.pz, 1, flag);
    ez = column_dot(it.px, it.py, it.pz, 2, flag);
    r.divided = 1'b0;
    if (persp_on && ez != 0) begin
      ex = clamp32((ex * (64'sd1 <<< FB)) / ez, flag);
      ey = clamp32((ey * (64'sd1 <<< FB)) / ez, flag);
      r.divided = 1'b1;
    end
    r.rx = word_t'(ex);
    r.ry = word_t'(ey);
    r.rz = word_t'(ez);
    r.clamped = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return word_t'($urandom_range(0, 1) ? 32'sh00010000 : 32'shffff0000);
      default: return word_t'(signed'(32'($urandom_range(0, 32'h0007ffff)))
                              - 32'sh00040000);
    endcase
  endfunction

  function automatic vtx_item_t make_load(int slot, word_t v);
    vtx_item_t it;
    it.kind = KIND_LOAD;
    it.slot = 4'(slot);
    it.coef = v;
    it.px = word_t'($urandom);
    it.py = word_t'($urandom);
    it.pz = word_t'($urandom);
    return it;
  endfunction

  function automatic vtx_item_t make_point(word_t x, word_t y, word_t z);
    vtx_item_t it;
    it.kind = KIND_POINT;
    it.slot = 4'($urandom);
    it.coef = word_t'($urandom);
    it.px = x;
    it.py = y;
    it.pz = z;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    vtx_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (in_tvalid && !in_tready) begin
    end else if (send_wait > 0) begin
      in_tvalid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (pending_items.size() > 0) begin
      it = pending_items.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= it.kind;
      in_tdata <= {4'b0, it.pz, it.py, it.px, it.coef, it.slot};
      send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // prediction at input acceptance
  always @(posedge clk) begin
    vtx_item_t it;
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coefs[i] = '0;
      coefs[0] = 32'sd1 <<< FB;
      coefs[4] = 32'sd1 <<< FB;
      coefs[8] = 32'sd1 <<< FB;
      persp_on = 1'b0;
    end else begin
      if (cfg_wr_en) persp_on = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        it.kind = kind_t'(in_tuser);
        it.slot = in_tdata[3:0];
        it.coef = in_tdata[35:4];
        it.px = in_tdata[67:36];
        it.py = in_tdata[99:68];
        it.pz = in_tdata[131:100];
        if (it.kind == KIND_LOAD) begin
          if (it.slot < NCOEF) coefs[it.slot] = it.coef;
        end else begin
          expected_points.push_back(transform_point(it));
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vtx_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $display("unexpected output transaction");
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (out_tdata[31:0] !== e.rx) report_mismatch("x", out_tdata[31:0], e.rx);
          if (out_tdata[63:32] !== e.ry) report_mismatch("y", out_tdata[63:32], e.ry);
          if (out_tdata[95:64] !== e.rz) report_mismatch("z", out_tdata[95:64], e.rz);
          if (out_tuser[0] !== e.divided)
            report_mismatch("was_divided", out_tuser[0], e.divided);
          if (out_tuser[1] !== e.clamped)
            report_mismatch("saturated", out_tuser[1], e.clamped);
        end
      end
      if (recv_wait > 0) begin
        out_tready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready)
          recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("vertex_transform_perspective_top_test NOT OK");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_tvalid || expected_points.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_persp(logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
        pending_items.push_back(make_load(s, rand_word()));
      end else begin
        pending_items.push_back(make_point(rand_word(), rand_word(), rand_word()));
      end
    end
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, extremes, ignored slots, zero z, divide
    pending_items.push_back(make_point(32'sh00010000, 32'shfffe0000, 32'sh00030000));
    pending_items.push_back(make_point(32'sh7fffffff, 32'sh80000000, 32'sh00000000));
    pending_items.push_back(make_load(9, 32'sh7fffffff));
    pending_items.push_back(make_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    pending_items.push_back(make_load(13, 32'sh12345678));
    pending_items.push_back(make_load(15, 32'sh80000000));
    pending_items.push_back(make_load(9, 32'sh00000000));
    pending_items.push_back(make_load(0, 32'sh80000000));
    pending_items.push_back(make_point(32'sh80000000, 32'sh00010000, 32'sh00000000));
    pending_items.push_back(make_load(0, 32'sh00010000));
    wait_drained();
    write_persp(1'b1);
    pending_items.push_back(make_point(32'sh00050000, 32'sh00030000, 32'sh00020000));
    pending_items.push_back(make_point(32'sh00050000, 32'sh00030000, 32'sh00000000));
    pending_items.push_back(make_point(32'sh7fffffff, 32'sh80000000, 32'sh00000001));
    pending_items.push_back(make_point(32'sh80000000, 32'sh7fffffff, 32'shffffffff));
    pending_items.push_back(make_load(11, 32'sh00000001));
    pending_items.push_back(make_point(32'sh00000000, 32'sh00000000, 32'sh00000000));
    pending_items.push_back(make_load(11, 32'sh00000000));

    for (int ph = 0; ph < 6; ph++) begin
      random_phase(215);
      wait_drained();
      write_persp(ph[0]);
    end
    wait_drained();
    if (errors == 0) begin
      $display("vertex_transform_perspective_top_test OK");
    end else begin
      $display("vertex_transform_perspective_top_test NOT OK");
    end
    $finish;
  end
endmodule
